FILE: hdl/swct_pkg.sv
// ----------------------------------------------------------------------------
// swct_pkg
// Shared widths, register indexes and datapath command types for the
// sliding window charge trigger.
// ----------------------------------------------------------------------------
package swct_pkg;

	localparam int TIME_W        = 32;
	localparam int CHARGE_W      = 24;
	localparam int SUM_OUT_W     = 31;
	localparam int MULT_W        = 7;
	localparam int WIN_W         = 20;
	localparam int CFG_W         = 31;
	localparam int CFG_IDX_W     = 1;
	localparam int DEFAULT_DEPTH = 64;

	localparam logic [SUM_OUT_W-1:0] SUM_MAX   = {SUM_OUT_W{1'b1}};
	localparam logic [MULT_W-1:0]    COUNT_MAX = {MULT_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_CHARGE_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS     = 1'd1;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_ADD,
		OP_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
		logic    update_best;
		logic    set_ovf;
		logic    clear;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} stat_t;

endpackage

FILE: hdl/swct_ram.sv
// ----------------------------------------------------------------------------
// swct_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module swct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/swct_dp.sv
// ----------------------------------------------------------------------------
// swct_dp
// Event datapath: running window sum through one shared add/subtract unit,
// occupancy counter, plus the event's best sum, best occupancy and overflow.
// ----------------------------------------------------------------------------
module swct_dp #(
	parameter int WINDOW_DEPTH = swct_pkg::DEFAULT_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  swct_pkg::cmd_t                   cmd,
	input  logic [swct_pkg::CHARGE_W-1:0]    operand,
	output swct_pkg::stat_t                  stat,
	output logic [swct_pkg::SUM_OUT_W-1:0]   best_sum,
	output logic [swct_pkg::MULT_W-1:0]      best_mult,
	output logic                             overflow
);

	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_RAW = swct_pkg::CHARGE_W + CNT_W;
	localparam int SUM_W  = (SUM_RAW > swct_pkg::SUM_OUT_W + 1) ? SUM_RAW
	                                                            : swct_pkg::SUM_OUT_W + 1;
	localparam int CMP_W  = (CNT_W > swct_pkg::MULT_W) ? CNT_W : swct_pkg::MULT_W;

	logic [SUM_W-1:0]              sum_q;
	logic [CNT_W-1:0]              count_q;
	logic [swct_pkg::SUM_OUT_W-1:0] best_sum_q;
	logic [CNT_W-1:0]              best_count_q;
	logic                          ovf_q;

	logic [SUM_W-1:0]              alu_res;
	logic [swct_pkg::SUM_OUT_W-1:0] sum_sat;
	logic [CMP_W-1:0]              best_wide;

	// shared add/subtract unit
	always_comb begin
		unique case (cmd.op)
			swct_pkg::OP_ADD: alu_res = sum_q + SUM_W'(operand);
			swct_pkg::OP_SUB: alu_res = sum_q - SUM_W'(operand);
			default:          alu_res = sum_q;
		endcase
	end

	assign sum_sat = (|sum_q[SUM_W-1:swct_pkg::SUM_OUT_W]) ? swct_pkg::SUM_MAX
	                                                        : sum_q[swct_pkg::SUM_OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q        <= '0;
			count_q      <= '0;
			best_sum_q   <= '0;
			best_count_q <= '0;
			ovf_q        <= 1'b0;
		end else if (cmd.clear) begin
			sum_q        <= '0;
			count_q      <= '0;
			best_sum_q   <= '0;
			best_count_q <= '0;
			ovf_q        <= 1'b0;
		end else begin
			sum_q <= alu_res;
			unique case (cmd.op)
				swct_pkg::OP_ADD: count_q <= count_q + CNT_W'(1);
				swct_pkg::OP_SUB: count_q <= count_q - CNT_W'(1);
				default:          count_q <= count_q;
			endcase
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.update_best) begin
				if (sum_sat > best_sum_q) begin
					best_sum_q <= sum_sat;
				end
				if (count_q > best_count_q) begin
					best_count_q <= count_q;
				end
			end
		end
	end

	assign best_wide  = CMP_W'(best_count_q);
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(WINDOW_DEPTH));
	assign best_sum   = best_sum_q;
	assign best_mult  = (best_wide > CMP_W'(swct_pkg::COUNT_MAX)) ? swct_pkg::COUNT_MAX
	                                                              : best_wide[swct_pkg::MULT_W-1:0];
	assign overflow   = ovf_q;

endmodule

FILE: hdl/sliding_window_charge_trigger.sv
// ----------------------------------------------------------------------------
// sliding_window_charge_trigger
// Sliding time window charge sum trigger over the primitives of one event.
// ----------------------------------------------------------------------------
// Each primitive word is taken in, then the sequencer steps through the
// window store: it evicts old entries in turn (peak time more than
// window_ticks behind the new one), drops the oldest if the store is full,
// then inserts the new entry and updates the best values; only then is the
// next primitive taken. The last primitive of an event also loads the result
// word, waiting while an earlier one is still held on the output. The pace
// is set by the single read port of the window store and the one shared
// add/subtract unit for the running sum. The result register lets the input
// side continue while a result word waits. No clearing pass after reset.
// ----------------------------------------------------------------------------
module sliding_window_charge_trigger #(
	parameter int WINDOW_DEPTH = swct_pkg::DEFAULT_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_we,
	input  logic [swct_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [swct_pkg::CFG_W-1:0]        cfg_data,

	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [swct_pkg::TIME_W-1:0]       peak_time,
	input  logic [swct_pkg::CHARGE_W-1:0]     charge_integral,
	input  logic                              event_end,

	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [swct_pkg::SUM_OUT_W-1:0]    max_window_sum,
	output logic [swct_pkg::MULT_W-1:0]       max_multiplicity,
	output logic                              event_passes,
	output logic                              fifo_overflowed
);

	localparam int PTR_W  = $clog2(WINDOW_DEPTH);
	localparam int WORD_W = swct_pkg::TIME_W + swct_pkg::CHARGE_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_INSERT,
		S_BEST,
		S_FINISH
	} state_t;

	state_t                           state_q;
	logic [swct_pkg::CFG_W-1:0]       threshold_q;
	logic [swct_pkg::WIN_W-1:0]       window_q;
	logic [swct_pkg::TIME_W-1:0]      time_q;
	logic [swct_pkg::CHARGE_W-1:0]    charge_q;
	logic                             last_q;
	logic [PTR_W-1:0]                 oldest_q;
	logic [PTR_W-1:0]                 newest_q;

	logic                             out_valid_q;
	logic [swct_pkg::SUM_OUT_W-1:0]   out_sum_q;
	logic [swct_pkg::MULT_W-1:0]      out_mult_q;
	logic                             out_pass_q;
	logic                             out_ovf_q;

	logic [WORD_W-1:0]                rd_word;
	logic [swct_pkg::TIME_W-1:0]      old_time;
	logic [swct_pkg::CHARGE_W-1:0]    old_charge;
	logic [swct_pkg::TIME_W-1:0]      time_gap;
	logic                             evict;
	logic                             drop_full;
	logic                             out_free;
	logic                             finish;
	logic [PTR_W-1:0]                 oldest_adv;
	logic [PTR_W-1:0]                 newest_adv;
	logic [PTR_W-1:0]                 rd_addr;
	logic                             wr_en;

	swct_pkg::cmd_t                   cmd;
	logic [swct_pkg::CHARGE_W-1:0]    operand;
	swct_pkg::stat_t                  stat;
	logic [swct_pkg::SUM_OUT_W-1:0]   best_sum;
	logic [swct_pkg::MULT_W-1:0]      best_mult;
	logic                             overflow;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		advance = (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign old_time   = rd_word[WORD_W-1:swct_pkg::CHARGE_W];
	assign old_charge = rd_word[swct_pkg::CHARGE_W-1:0];
	assign time_gap   = time_q - old_time;

	// time going backwards never evicts
	assign evict     = (state_q == S_LOOK) && !stat.empty && (time_q >= old_time) &&
	                   (time_gap > swct_pkg::TIME_W'(window_q));
	assign drop_full = (state_q == S_LOOK) && !evict && stat.full;
	assign out_free  = !out_valid_q || out_ready;
	assign finish    = (state_q == S_FINISH) && out_free;

	assign oldest_adv = advance(oldest_q);
	assign newest_adv = advance(newest_q);
	// fetch the next oldest entry ahead so evictions can run back to back
	assign rd_addr    = (evict || drop_full) ? oldest_adv : oldest_q;
	assign wr_en      = (state_q == S_INSERT);

	always_comb begin
		cmd.op          = swct_pkg::OP_NONE;
		cmd.update_best = (state_q == S_BEST);
		cmd.set_ovf     = drop_full;
		cmd.clear       = finish;
		operand         = old_charge;
		if (evict || drop_full) begin
			cmd.op = swct_pkg::OP_SUB;
		end else if (state_q == S_INSERT) begin
			cmd.op  = swct_pkg::OP_ADD;
			operand = charge_q;
		end
	end

	swct_ram #(
		.WIDTH(WORD_W),
		.DEPTH(WINDOW_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(newest_q),
		.wdata({time_q, charge_q}),
		.raddr(rd_addr),
		.rdata(rd_word)
	);

	swct_dp #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.operand  (operand),
		.stat     (stat),
		.best_sum (best_sum),
		.best_mult(best_mult),
		.overflow (overflow)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			window_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				swct_pkg::REG_CHARGE_THRESHOLD: threshold_q <= cfg_data;
				swct_pkg::REG_WINDOW_TICKS:     window_q    <= cfg_data[swct_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			time_q      <= '0;
			charge_q    <= '0;
			last_q      <= 1'b0;
			oldest_q    <= '0;
			newest_q    <= '0;
			out_valid_q <= 1'b0;
			out_sum_q   <= '0;
			out_mult_q  <= '0;
			out_pass_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						time_q   <= peak_time;
						charge_q <= charge_integral;
						last_q   <= event_end;
						state_q  <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (evict) begin
						oldest_q <= oldest_adv;
					end else begin
						if (drop_full) begin
							oldest_q <= oldest_adv;
						end
						state_q <= S_INSERT;
					end
				end
				S_INSERT: begin
					newest_q <= newest_adv;
					state_q  <= S_BEST;
				end
				S_BEST: begin
					state_q <= last_q ? S_FINISH : S_IDLE;
				end
				S_FINISH: begin
					if (out_free) begin
						out_sum_q   <= best_sum;
						out_mult_q  <= best_mult;
						out_pass_q  <= (best_sum > threshold_q);
						out_ovf_q   <= overflow;
						oldest_q    <= '0;
						newest_q    <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready         = (state_q == S_IDLE);
	assign out_valid        = out_valid_q;
	assign max_window_sum   = out_sum_q;
	assign max_multiplicity = out_mult_q;
	assign event_passes     = out_pass_q;
	assign fifo_overflowed  = out_ovf_q;

endmodule

FILE: tb/sv/sliding_window_charge_trigger_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_charge_trigger_tb
// Self-checking bench for the sliding window charge trigger. A short table
// of primitives (field extremes, equal and backward times, window edges,
// threshold edges) runs first, then random events under several register
// settings, including bursts that overflow the window store. Each result
// word is compared per field with a typed row value or an in-bench window model.
// ----------------------------------------------------------------------------
module sliding_window_charge_trigger_tb;

	localparam int DEPTH          = swct_pkg::DEFAULT_DEPTH;
	localparam int PTR_W          = $clog2(DEPTH);
	localparam int SETTLE_CYCLES  = 100;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_ITEMS    = 125;

	typedef struct packed {
		logic [swct_pkg::SUM_OUT_W-1:0] sum;
		logic [swct_pkg::MULT_W-1:0]    mult;
		logic                           passes;
		logic                           overflowed;
	} trig_result_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t                       kind;
		logic [swct_pkg::CFG_IDX_W-1:0]  idx;
		logic [swct_pkg::CFG_W-1:0]      value;
		logic [swct_pkg::TIME_W-1:0]     t;
		logic [swct_pkg::CHARGE_W-1:0]   q;
		logic                            last;
		logic                            typed;
		trig_result_t                    res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [swct_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [swct_pkg::CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [swct_pkg::TIME_W-1:0] peak_time;
	logic [swct_pkg::CHARGE_W-1:0] charge_integral;
	logic event_end;
	logic out_valid;
	logic out_ready;
	logic [swct_pkg::SUM_OUT_W-1:0] max_window_sum;
	logic [swct_pkg::MULT_W-1:0] max_multiplicity;
	logic event_passes;
	logic fifo_overflowed;

	// typed expectation that travels with the word on the input
	logic item_typed;
	trig_result_t item_res;

	// register copies
	logic [swct_pkg::CFG_W-1:0] pass_level = '0;
	logic [swct_pkg::WIN_W-1:0] span_ticks = '0;

	// window model
	logic [swct_pkg::TIME_W-1:0]   win_time [DEPTH];
	logic [swct_pkg::CHARGE_W-1:0] win_charge [DEPTH];
	logic [PTR_W-1:0]              head_idx = '0;
	logic [PTR_W-1:0]              tail_idx = '0;
	int                            held_n = 0;
	longint unsigned               run_sum = 0;
	bit [swct_pkg::SUM_OUT_W-1:0]  top_sum = '0;
	int                            top_n = 0;
	bit                            dropped = 1'b0;

	trig_result_t pending_results[$];
	stim_row_t    stim_rows[$];
	int           fault_count = 0;
	int           quiet_cycles = 0;
	int           results_seen = 0;
	bit           no_idle = 1'b0;
	bit           hold_done = 1'b0;

	sliding_window_charge_trigger #(
		.WINDOW_DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.peak_time(peak_time),
		.charge_integral(charge_integral),
		.event_end(event_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.max_window_sum(max_window_sum),
		.max_multiplicity(max_multiplicity),
		.event_passes(event_passes),
		.fifo_overflowed(fifo_overflowed)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		else if (r < 90)
			return int'($urandom_range(1, 3));
		else if (r < 97)
			return int'($urandom_range(4, 12));
		else
			return int'($urandom_range(20, 60));
	endfunction

	function automatic logic [swct_pkg::CHARGE_W-1:0] pick_charge();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return swct_pkg::CHARGE_W'($urandom_range(0, 24'hFF_FFFF));
		else if (r < 85)
			return swct_pkg::CHARGE_W'($urandom_range(0, 255));
		else
			return 24'hFF_FFFF;
	endfunction

	function automatic void evict_oldest();
		run_sum = run_sum - win_charge[head_idx];
		head_idx = (head_idx == PTR_W'(DEPTH - 1)) ? '0 : head_idx + PTR_W'(1);
		held_n--;
	endfunction

	// Advances the window by one primitive; returns 1 when a result word is due.
	function automatic bit charge_window_step(input logic [swct_pkg::TIME_W-1:0] t,
			input logic [swct_pkg::CHARGE_W-1:0] q, input logic last,
			output trig_result_t res);
		logic [swct_pkg::SUM_OUT_W-1:0] clipped;
		res = '0;
		while (held_n > 0 && t >= win_time[head_idx] &&
				(t - win_time[head_idx]) >
				{{(swct_pkg::TIME_W-swct_pkg::WIN_W){1'b0}}, span_ticks})
			evict_oldest();
		if (held_n >= DEPTH) begin
			evict_oldest();
			dropped = 1'b1;
		end
		win_time[tail_idx] = t;
		win_charge[tail_idx] = q;
		tail_idx = (tail_idx == PTR_W'(DEPTH - 1)) ? '0 : tail_idx + PTR_W'(1);
		held_n++;
		run_sum = run_sum + q;
		clipped = (run_sum > swct_pkg::SUM_MAX) ? swct_pkg::SUM_MAX
		                                        : run_sum[swct_pkg::SUM_OUT_W-1:0];
		if (clipped > top_sum)
			top_sum = clipped;
		if (held_n > top_n)
			top_n = held_n;
		if (!last)
			return 1'b0;
		res.sum = top_sum;
		res.mult = (top_n > swct_pkg::COUNT_MAX) ? swct_pkg::COUNT_MAX
		                                         : top_n[swct_pkg::MULT_W-1:0];
		res.passes = (top_sum > pass_level);
		res.overflowed = dropped;
		head_idx = '0;
		tail_idx = '0;
		held_n = 0;
		run_sum = 0;
		top_sum = '0;
		top_n = 0;
		dropped = 1'b0;
		return 1'b1;
	endfunction

	function automatic void row_item(input logic [swct_pkg::TIME_W-1:0] t,
			input logic [swct_pkg::CHARGE_W-1:0] q, input logic last, input logic typed,
			input logic [swct_pkg::SUM_OUT_W-1:0] sum, input logic [swct_pkg::MULT_W-1:0] mult,
			input logic passes, input logic ovf);
		stim_row_t r;
		r.kind = ROW_ITEM;
		r.idx = swct_pkg::REG_CHARGE_THRESHOLD;
		r.value = '0;
		r.t = t;
		r.q = q;
		r.last = last;
		r.typed = typed;
		r.res.sum = sum;
		r.res.mult = mult;
		r.res.passes = passes;
		r.res.overflowed = ovf;
		stim_rows.insert(stim_rows.size(), r);
	endfunction

	function automatic void row_reg(input logic [swct_pkg::CFG_IDX_W-1:0] idx,
			input logic [swct_pkg::CFG_W-1:0] value);
		stim_row_t r;
		r.kind = ROW_REG;
		r.idx = idx;
		r.value = value;
		r.t = '0;
		r.q = '0;
		r.last = 1'b0;
		r.typed = 1'b0;
		r.res = '0;
		stim_rows.insert(stim_rows.size(), r);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want != got) begin
			fault_count++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Called at a rising edge; returns at the edge where the word is taken.
	task automatic offer(input logic [swct_pkg::TIME_W-1:0] t,
			input logic [swct_pkg::CHARGE_W-1:0] q, input logic last, input logic typed,
			input trig_result_t res);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		peak_time <= t;
		charge_integral <= q;
		event_end <= last;
		item_typed <= typed;
		item_res <= res;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Quiesce: input idle, all results in, then let the sequencer finish.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending_results.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [swct_pkg::CFG_IDX_W-1:0] idx,
			input logic [swct_pkg::CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == swct_pkg::REG_CHARGE_THRESHOLD)
			pass_level = value;
		else
			span_ticks = value[swct_pkg::WIN_W-1:0];
		@(posedge clk);
	endtask

	task automatic random_event(output int sent);
		int unsigned shape;
		int unsigned len;
		logic [swct_pkg::TIME_W-1:0] t;
		shape = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0)
			t = 32'hFFFF_FFFF - $urandom_range(0, 2000);
		else
			t = $urandom();
		if (shape < 4)
			len = $urandom_range(65, 90);
		else if (shape < 10)
			len = $urandom_range(1, 6);
		else
			len = $urandom_range(1, 14);
		for (int i = 0; i < len; i++) begin
			offer(t, pick_charge(), i == len - 1, 1'b0, '0);
			if (shape < 4) begin
				// burst at one time fills the store; the closing word flushes it
				if (i == len - 2)
					t = t + span_ticks + 1 + $urandom_range(0, 50);
			end else if (shape < 10) begin
				t = $urandom();
			end else if (shape < 18) begin
				if ($urandom_range(0, 2) == 0)
					t = t - $urandom_range(1, 500);
				else
					t = t + span_ticks + 1 + $urandom_range(0, 100);
			end else begin
				if ($urandom_range(0, 7) == 0)
					t = t + span_ticks + 1 + $urandom_range(0, 100);
				else
					t = t + $urandom_range(0, span_ticks / 3 + 1);
			end
		end
		sent = int'(len);
	endtask

	always @(posedge clk) begin : monitor
		trig_result_t pred;
		trig_result_t want;
		bit moved;
		if (arst_n === 1'b1) begin
			moved = 1'b0;
			if (in_valid && in_ready) begin
				moved = 1'b1;
				if (charge_window_step(peak_time, charge_integral, event_end, pred))
					pending_results.insert(pending_results.size(),
						item_typed ? item_res : pred);
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				results_seen++;
				if (pending_results.size() == 0) begin
					fault_count++;
					$display("%0t: result word with none pending: sum %0d mult %0d pass %0b ovf %0b",
						$time, max_window_sum, max_multiplicity, event_passes, fifo_overflowed);
				end else begin
					want = pending_results[0];
					pending_results.delete(0);
					check_field("max_window_sum", 32'(want.sum), 32'(max_window_sum));
					check_field("max_multiplicity", 32'(want.mult), 32'(max_multiplicity));
					check_field("event_passes", 32'(want.passes), 32'(event_passes));
					check_field("fifo_overflowed", 32'(want.overflowed), 32'(fifo_overflowed));
				end
			end
			if (moved) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
					$display("sliding_window_charge_trigger: mismatch");
					$finish;
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold-off to back up the input
	initial begin : result_sink
		int n;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!hold_done && results_seen >= 40) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			n = idle_len();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : stimulus
		int n;
		int sent_total;
		logic [swct_pkg::CFG_W-1:0] lvl;
		logic [swct_pkg::WIN_W-1:0] span;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= swct_pkg::REG_CHARGE_THRESHOLD;
		cfg_data <= '0;
		in_valid <= 1'b0;
		peak_time <= '0;
		charge_integral <= '0;
		event_end <= 1'b0;
		item_typed <= 1'b0;
		item_res <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: threshold 0, window 0 (any later time evicts)
		//       peak_time      charge        end   typ   sum           mult   pass  ovf
		row_item(32'h0000_0000, 24'h00_0000, 1'b1, 1'b1, 31'd0,        7'd1, 1'b0, 1'b0);
		row_item(32'd100,       24'hFF_FFFF, 1'b1, 1'b1, 31'h0FF_FFFF, 7'd1, 1'b1, 1'b0);
		row_item(32'hFFFF_FFFF, 24'd1,       1'b1, 1'b1, 31'd1,        7'd1, 1'b1, 1'b0);
		// equal times share the window
		row_item(32'd50,        24'd10,      1'b0, 1'b0, 31'd0,        7'd0, 1'b0, 1'b0);
		row_item(32'd50,        24'd20,      1'b0, 1'b0, 31'd0,        7'd0, 1'b0, 1'b0);
		row_item(32'd50,        24'd30,      1'b1, 1'b1, 31'd60,       7'd3, 1'b1, 1'b0);
		// each later time pushes the previous one out
		row_item(32'd10,        24'd5,       1'b0, 1'b0, 31'd0,        7'd0, 1'b0, 1'b0);
		row_item(32'd11,        24'd7,       1'b0, 1'b0, 31'd0,        7'd0, 1'b0, 1'b0);
		row_item(32'd12,        24'd9,       1'b1, 1'b1, 31'd9,        7'd1, 1'b1, 1'b0);
		// time going backwards keeps the older entry
		row_item(32'd1000,      24'd4,       1'b0, 1'b0, 31'd0,        7'd0, 1'b0, 1'b0);
		row_item(32'd900,       24'd6,       1'b0, 1'b0, 31'd0,        7'd0, 1'b0, 1'b0);
		row_item(32'd2000,      24'd1,       1'b1, 1'b1, 31'd10,       7'd2, 1'b1, 1'b0);
		row_item(32'h0000_0000, 24'hFF_FFFF, 1'b0, 1'b0, 31'd0,        7'd0, 1'b0, 1'b0);
		row_item(32'h0000_0000, 24'hFF_FFFF, 1'b1, 1'b1, 31'h1FF_FFFE, 7'd2, 1'b1, 1'b0);
		row_item(32'hAAAA_AAAA, 24'h55_5555, 1'b0, 1'b0, 31'd0,        7'd0, 1'b0, 1'b0);
		row_item(32'h5555_5555, 24'hAA_AAAA, 1'b1, 1'b1, 31'h0FF_FFFF, 7'd2, 1'b1, 1'b0);
		// widest window, highest threshold: nothing passes
		row_reg(swct_pkg::REG_CHARGE_THRESHOLD, 31'h7FFF_FFFF);
		row_reg(swct_pkg::REG_WINDOW_TICKS, 31'h000F_FFFF);
		row_item(32'd5,         24'hFF_FFFF, 1'b0, 1'b0, 31'd0,        7'd0, 1'b0, 1'b0);
		row_item(32'h0010_0004, 24'd1,       1'b0, 1'b0, 31'd0,        7'd0, 1'b0, 1'b0);
		row_item(32'h0010_0005, 24'd2,       1'b1, 1'b1, 31'h100_0000, 7'd2, 1'b0, 1'b0);
		// threshold is strict
		row_reg(swct_pkg::REG_CHARGE_THRESHOLD, 31'd60);
		row_item(32'd7,         24'd60,      1'b1, 1'b1, 31'd60,       7'd1, 1'b0, 1'b0);
		row_item(32'd8,         24'd61,      1'b1, 1'b1, 31'd61,       7'd1, 1'b1, 1'b0);
		row_item(32'd20,        24'd100,     1'b0, 1'b0, 31'd0,        7'd0, 1'b0, 1'b0);
		row_item(32'd30,        24'd200,     1'b0, 1'b0, 31'd0,        7'd0, 1'b0, 1'b0);
		row_item(32'hFFFF_0000, 24'd300,     1'b1, 1'b0, 31'd0,        7'd0, 1'b0, 1'b0);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_REG) begin
				settle();
				write_reg(stim_rows[i].idx, stim_rows[i].value);
			end else begin
				offer(stim_rows[i].t, stim_rows[i].q, stim_rows[i].last,
					stim_rows[i].typed, stim_rows[i].res);
			end
		end

		for (int ph = 0; ph < 6; ph++) begin
			settle();
			case (ph)
				0: begin
					lvl = swct_pkg::SUM_MAX;
					span = 20'hF_FFFF;
				end
				1: begin
					lvl = '0;
					span = '0;
				end
				default: begin
					lvl = swct_pkg::CFG_W'($urandom_range(0, 60_000_000));
					if ($urandom_range(0, 1) == 0)
						span = swct_pkg::WIN_W'($urandom_range(0, 4000));
					else
						span = swct_pkg::WIN_W'($urandom_range(0, 20'hF_FFFF));
				end
			endcase
			write_reg(swct_pkg::REG_CHARGE_THRESHOLD, lvl);
			write_reg(swct_pkg::REG_WINDOW_TICKS,
				{{(swct_pkg::CFG_W-swct_pkg::WIN_W){1'b0}}, span});
			no_idle = (ph == 3);
			sent_total = 0;
			while (sent_total < PHASE_ITEMS) begin
				random_event(n);
				sent_total += n;
			end
		end
		no_idle = 1'b0;
		settle();

		if (fault_count == 0)
			$display("sliding_window_charge_trigger: match");
		else
			$display("sliding_window_charge_trigger: mismatch");
		$finish;
	end

endmodule

FILE: files.f
hdl/swct_pkg.sv
hdl/swct_ram.sv
hdl/swct_dp.sv
hdl/sliding_window_charge_trigger.sv
tb/sv/sliding_window_charge_trigger_tb.sv
